/* rtl/ppbc_pkg.sv */
// Shared types, constants and helper functions for the per-position base composition block.
// No dependencies; every other file of the block imports this package.
package ppbc_pkg;

  localparam int MAX_POSITIONS = 256;
  localparam int COUNT_BITS    = 32;
  localparam int NUM_CLASSES   = 5;
  localparam int POS_W         = $clog2(MAX_POSITIONS);
  localparam int OUT_W         = 32;
  localparam int LEN_W         = 9;

  // Base classes
  localparam logic [2:0] CLS_A     = 3'd0;
  localparam logic [2:0] CLS_T     = 3'd1;
  localparam logic [2:0] CLS_G     = 3'd2;
  localparam logic [2:0] CLS_C     = 3'd3;
  localparam logic [2:0] CLS_OTHER = 3'd4;

  // ASCII letters
  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_T_UP = 8'h54;
  localparam logic [7:0] CH_T_LO = 8'h74;
  localparam logic [7:0] CH_G_UP = 8'h47;
  localparam logic [7:0] CH_G_LO = 8'h67;
  localparam logic [7:0] CH_C_UP = 8'h43;
  localparam logic [7:0] CH_C_LO = 8'h63;

  // Input actions
  localparam logic ACT_COUNT = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  // One memory row: all counters of one position
  typedef struct packed {
    cnt_t cnt_a;
    cnt_t cnt_t;
    cnt_t cnt_g;
    cnt_t cnt_c;
    cnt_t cnt_other;
    cnt_t cnt_cov;
  } row_t;

  // Access request to the counter memory
  typedef struct packed {
    logic             rd_en;
    logic [POS_W-1:0] rd_addr;
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
  } ram_req_t;

  function automatic logic [2:0] classify(input logic [7:0] ch);
    logic [2:0] cls;
    unique case (ch)
      CH_A_UP, CH_A_LO: cls = CLS_A;
      CH_T_UP, CH_T_LO: cls = CLS_T;
      CH_G_UP, CH_G_LO: cls = CLS_G;
      CH_C_UP, CH_C_LO: cls = CLS_C;
      default:          cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

  function automatic cnt_t bump(input cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  // Report a counter on 32 bits, saturating if the counter is wider
  function automatic logic [OUT_W-1:0] clip_out(input cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'h0000_0000_FFFF_FFFF) ? '1 : w[OUT_W-1:0];
  endfunction

endpackage

/* rtl/ppbc_count_ram.sv */
// Counter memory: one row of six counters per read position, with registered read data.
// Per-row valid flags make unwritten rows read as zero after reset. Uses ppbc_pkg.
module ppbc_count_ram (
  input  logic               clk,
  input  logic               rst_n,
  input  ppbc_pkg::ram_req_t req,
  input  ppbc_pkg::row_t     wr_row,
  output ppbc_pkg::row_t     rd_row
);
  import ppbc_pkg::*;

  row_t                     mem [MAX_POSITIONS];
  logic [MAX_POSITIONS-1:0] row_vld_r;
  row_t                     rd_data_r;
  logic                     rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_row;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= row_vld_r[req.rd_addr];
      end
    end
  end

  assign rd_row = rd_vld_r ? rd_data_r : '0;

endmodule

/* rtl/ppbc_row_update.sv */
// Read-modify-write datapath: bumps the class counter and the coverage counter of one row.
// Counters saturate at all ones. Uses ppbc_pkg.
module ppbc_row_update (
  input  ppbc_pkg::row_t   row_in,
  input  logic [2:0]       cls,
  output ppbc_pkg::row_t   row_out
);
  import ppbc_pkg::*;

  always_comb begin
    row_out = row_in;
    unique case (cls)
      CLS_A:   row_out.cnt_a     = bump(row_in.cnt_a);
      CLS_T:   row_out.cnt_t     = bump(row_in.cnt_t);
      CLS_G:   row_out.cnt_g     = bump(row_in.cnt_g);
      CLS_C:   row_out.cnt_c     = bump(row_in.cnt_c);
      default: row_out.cnt_other = bump(row_in.cnt_other);
    endcase
    row_out.cnt_cov = bump(row_in.cnt_cov);
  end

endmodule

/* rtl/per_position_base_composition.sv */
// Per-position base composition counter. Bases of sequencing reads arrive one per
// transfer with a last-of-read mark; each is classified (A, T, G, C, other, case
// insensitive) and the class and coverage counters at its position in the read are
// incremented, saturating at all ones. Bases past position 255 are dropped and set a
// sticky truncated flag. A query transfer returns one result with the five class
// counts and the coverage of one position (zero beyond capacity), plus the longest
// read length and the truncated flag; a counted base returns nothing. Each item is
// taken in the idle state and finished in the work state: the counter memory is read
// in the accepting cycle and its registered read data written back (or the result
// loaded) in the work state. Only one item is in flight, so no two accesses overlap on the same row.
// A waiting result sits in the output register and does not block counting; a query
// waits in the work state until the output register is free. The counters read as
// zero straight after reset through per-row valid flags: no clearing pass is needed.
// Depends on ppbc_pkg, ppbc_count_ram and ppbc_row_update.
module per_position_base_composition (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_base_char,
  input  logic        in_last_in_read,
  input  logic [7:0]  in_query_position,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_count_a,
  output logic [31:0] out_count_t,
  output logic [31:0] out_count_g,
  output logic [31:0] out_count_c,
  output logic [31:0] out_count_other,
  output logic [31:0] out_coverage,
  output logic [8:0]  out_longest_read,
  output logic        out_truncated
);
  import ppbc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  // control state
  logic             state_r,     state_nxt;
  logic [POS_W:0]   pos_r,       pos_nxt;      // position in current read, 0..MAX
  logic [POS_W:0]   longest_r,   longest_nxt;
  logic             overflow_r,  overflow_nxt;
  logic             out_valid_r, out_valid_nxt;

  // item held for the work state
  logic             act_r;
  logic             do_wr_r;     // base lies within capacity
  logic             q_in_r;      // query position within capacity
  logic [2:0]       cls_r;
  logic [POS_W-1:0] addr_r;

  // result register
  logic [OUT_W-1:0] res_a_r, res_t_r, res_g_r, res_c_r, res_o_r, res_cov_r;
  logic [LEN_W-1:0] res_len_r;
  logic             res_trunc_r;

  logic             accept;
  logic             out_free;
  logic             load_res;
  logic             base_fits;
  logic             q_fits;
  logic [POS_W-1:0] q_addr;
  ram_req_t         ram_req;
  row_t             rd_row;
  row_t             wr_row;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign load_res  = (state_r == ST_WORK) && (act_r == ACT_QUERY) && out_free;
  assign base_fits = (pos_r < (POS_W+1)'(MAX_POSITIONS));
  assign q_fits    = (32'(in_query_position) < 32'(MAX_POSITIONS));
  assign q_addr    = POS_W'(in_query_position);

  // memory port: read on transfer, write back in the following cycle
  always_comb begin
    ram_req.rd_en   = accept && ((in_action == ACT_QUERY) ? q_fits : base_fits);
    ram_req.rd_addr = (in_action == ACT_QUERY) ? q_addr : pos_r[POS_W-1:0];
    ram_req.wr_en   = (state_r == ST_WORK) && (act_r == ACT_COUNT) && do_wr_r;
    ram_req.wr_addr = addr_r;
  end

  ppbc_count_ram u_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ram_req),
    .wr_row (wr_row),
    .rd_row (rd_row)
  );

  ppbc_row_update u_upd (
    .row_in  (rd_row),
    .cls     (cls_r),
    .row_out (wr_row)
  );

  // position tracking is settled at the transfer itself
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    longest_nxt   = longest_r;
    overflow_nxt  = overflow_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_WORK;
          if (in_action == ACT_COUNT) begin
            if (base_fits) begin
              pos_nxt = pos_r + (POS_W+1)'(1);
              if (pos_nxt > longest_r) begin
                longest_nxt = pos_nxt;
              end
            end else begin
              overflow_nxt = 1'b1;
            end
            if (in_last_in_read) begin
              pos_nxt = '0;
            end
          end
        end
      end
      default: begin
        if (act_r == ACT_COUNT) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      longest_r   <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
      act_r       <= ACT_COUNT;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      longest_r   <= longest_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        act_r <= in_action;
      end
    end
  end

  // item payload, held through the work state
  always_ff @(posedge clk) begin
    if (accept) begin
      do_wr_r <= base_fits;
      q_in_r  <= q_fits;
      cls_r   <= classify(in_base_char);
      addr_r  <= pos_r[POS_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_res) begin
      res_a_r     <= q_in_r ? clip_out(rd_row.cnt_a)     : '0;
      res_t_r     <= q_in_r ? clip_out(rd_row.cnt_t)     : '0;
      res_g_r     <= q_in_r ? clip_out(rd_row.cnt_g)     : '0;
      res_c_r     <= q_in_r ? clip_out(rd_row.cnt_c)     : '0;
      res_o_r     <= q_in_r ? clip_out(rd_row.cnt_other) : '0;
      res_cov_r   <= q_in_r ? clip_out(rd_row.cnt_cov)   : '0;
      res_len_r   <= LEN_W'(longest_r);
      res_trunc_r <= overflow_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_count_a      = res_a_r;
  assign out_count_t      = res_t_r;
  assign out_count_g      = res_g_r;
  assign out_count_c      = res_c_r;
  assign out_count_other  = res_o_r;
  assign out_coverage     = res_cov_r;
  assign out_longest_read = res_len_r;
  assign out_truncated    = res_trunc_r;

endmodule
